>>> sv/hccm_pkg.sv
// shared constants, types and codes for the hashed context count model
`default_nettype none
package hccm_pkg;
  localparam int ORDER_LIMIT   = 4;
  localparam int TABLE_ENTRIES = 256;

  localparam logic [31:0] FNV_OFFSET = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;

  localparam int CNT_W        = 12;
  localparam int NSYM         = 256;
  localparam int HALVE_LIMIT  = 4000;
  localparam int WEIGHT_W     = 21;
  localparam int CFG_W        = 3;
  localparam int CFG_RESET    = 4;

  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic       is_update;
    logic [7:0] symbol;
  } item_t;
endpackage
`default_nettype wire

>>> sv/hccm_if.sv
// request and result channel interfaces
`default_nettype none
interface hccm_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] symbol;
  modport source (output valid, output req_type, output symbol, input ready);
  modport sink (input valid, input req_type, input symbol, output ready);
endinterface

interface hccm_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] symbol_weight;
  logic [20:0] total_weight;
  modport source (output valid, output symbol_weight, output total_weight, input ready);
  modport sink (input valid, input symbol_weight, input total_weight, output ready);
endinterface
`default_nettype wire

>>> sv/hccm_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module hccm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> sv/hccm_front.sv
// request intake: classification and two entry queue towards the back end
`default_nettype none
module hccm_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  hccm_in_if.sink           in_chan,
  input  wire logic         clearing,
  output logic              item_valid,
  output hccm_pkg::item_t   item,
  input  wire logic         item_pop
);
  hccm_pkg::item_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;
  hccm_pkg::item_t new_item;

  assign in_chan.ready = (cnt_r != 2'd2) && !clearing;
  assign push          = in_chan.valid && in_chan.ready;
  assign new_item.is_update = (in_chan.req_type == hccm_pkg::REQ_UPDATE);
  assign new_item.symbol    = in_chan.symbol;

  assign item_valid = (cnt_r != 2'd0);
  assign item       = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !item_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && item_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (item_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_item;
    end
  end
endmodule
`default_nettype wire

>>> sv/hccm_back.sv
// sequencer: hashing, table access, halving sweep, result register
`default_nettype none
module hccm_back #(
  parameter int ORDER_LIMIT   = hccm_pkg::ORDER_LIMIT,
  parameter int TABLE_ENTRIES = hccm_pkg::TABLE_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [hccm_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       item_valid,
  input  wire hccm_pkg::item_t            item,
  output logic                            item_pop,
  output logic                            clearing,
  hccm_out_if.source                      out_chan
);
  localparam int NODES     = (ORDER_LIMIT + 1) * TABLE_ENTRIES;
  localparam int NODE_W    = $clog2(NODES);
  localparam int CNT_DEPTH = NODES * hccm_pkg::NSYM;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int OW        = $clog2(ORDER_LIMIT + 1);
  localparam int HIDX_W    = (ORDER_LIMIT > 1) ? $clog2(ORDER_LIMIT) : 1;
  localparam int ENT_W     = $clog2(TABLE_ENTRIES);
  localparam int RECIP_SHIFT = 32 + ENT_W;
  localparam logic [32:0] RECIP = 33'(((65'(1) << RECIP_SHIFT) + 65'(TABLE_ENTRIES)
                                      - 65'(1)) / 65'(TABLE_ENTRIES));
  localparam bit IS_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int CW        = hccm_pkg::CNT_W;
  localparam int WW        = hccm_pkg::WEIGHT_W;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_EVAL  = 4'd5;
  localparam logic [3:0] ST_HALVE = 4'd6;
  localparam logic [3:0] ST_DONE  = 4'd7;
  localparam logic [3:0] ST_SUB   = 4'd8;

  logic [3:0]                 state_r, state_nxt;
  logic [CNT_AW-1:0]          clr_r, clr_nxt;
  logic [hccm_pkg::CFG_W-1:0] order_cap_r;
  logic [7:0]                 hist_r [ORDER_LIMIT];
  logic [7:0]                 hist_nxt [ORDER_LIMIT];
  logic [OW-1:0]              len_r, len_nxt;
  logic                       upd_r, upd_nxt;
  logic [7:0]                 sym_r, sym_nxt;
  logic [OW-1:0]              ord_r, ord_nxt;
  logic [OW-1:0]              top_r, top_nxt;
  logic [OW-1:0]              k_r, k_nxt;
  logic [31:0]                h_r, h_nxt;
  logic [31:0]                quo_r, quo_nxt;
  logic [ENT_W-1:0]           ent_r, ent_nxt;
  logic                       halved_r, halved_nxt;
  logic [8:0]                 hs_r, hs_nxt;
  logic [19:0]                acc_r, acc_nxt;
  logic [WW-1:0]              sw_r, sw_nxt, tw_r, tw_nxt;
  logic                       ov_r, ov_nxt;
  logic [WW-1:0]              osw_r, osw_nxt, otw_r, otw_nxt;

  logic [NODE_W-1:0] node;
  logic [OW-1:0]     eff_order, first_top;
  logic [HIDX_W-1:0] hidx;
  logic [31:0]       h_mix, h_mul;
  logic [64:0]       quo_prod;
  logic [31:0]       rem_full;
  logic [CW-1:0]     half_cnt;
  logic [31:0]       cnt_wt, tot_wt;

  logic              cnt_we, tot_we;
  logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0]     cnt_wdata, cnt_rdata;
  logic [NODE_W-1:0] tot_waddr, tot_raddr;
  logic [CW-1:0]     tot_wdata, tot_rdata;

  hccm_ram #(.WIDTH(CW), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  hccm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_tot_ram (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(tot_raddr), .rdata(tot_rdata)
  );

  assign clearing = (state_r == ST_CLR);
  assign node     = NODE_W'(int'(ord_r) * TABLE_ENTRIES + int'(ent_r));
  assign eff_order = (int'(order_cap_r) > ORDER_LIMIT) ? OW'(ORDER_LIMIT) : OW'(order_cap_r);
  assign first_top = (eff_order < len_r) ? eff_order : len_r;
  assign hidx     = HIDX_W'(ORDER_LIMIT - int'(ord_r) + int'(k_r));
  assign h_mix    = h_r ^ {24'd0, hist_r[hidx]};
  assign h_mul    = h_mix * hccm_pkg::FNV_PRIME;
  assign quo_prod = 65'(h_r) * 65'(RECIP);
  assign rem_full = h_r - quo_r * 32'(TABLE_ENTRIES);
  assign half_cnt = cnt_rdata >> 1;
  assign cnt_wt   = 32'(cnt_rdata) << {ord_r, 1'b0};
  assign tot_wt   = 32'(tot_rdata) << {ord_r, 1'b0};

  assign out_chan.valid         = ov_r;
  assign out_chan.symbol_weight = osw_r;
  assign out_chan.total_weight  = otw_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    len_nxt    = len_r;
    upd_nxt    = upd_r;
    sym_nxt    = sym_r;
    ord_nxt    = ord_r;
    top_nxt    = top_r;
    k_nxt      = k_r;
    h_nxt      = h_r;
    quo_nxt    = quo_r;
    ent_nxt    = ent_r;
    halved_nxt = halved_r;
    hs_nxt     = hs_r;
    acc_nxt    = acc_r;
    sw_nxt     = sw_r;
    tw_nxt     = tw_r;
    ov_nxt     = ov_r;
    osw_nxt    = osw_r;
    otw_nxt    = otw_r;
    for (int i = 0; i < ORDER_LIMIT; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    item_pop  = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = {node, sym_r};
    cnt_wdata = cnt_rdata + CW'(1);
    cnt_raddr = {node, sym_r};
    tot_we    = 1'b0;
    tot_waddr = node;
    tot_wdata = tot_rdata + CW'(1);
    tot_raddr = node;

    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        tot_we    = (int'(clr_r) < NODES);
        tot_waddr = clr_r[NODE_W-1:0];
        tot_wdata = '0;
        clr_nxt   = clr_r + CNT_AW'(1);
        if (int'(clr_r) == CNT_DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          upd_nxt    = item.is_update;
          sym_nxt    = item.symbol;
          ord_nxt    = '0;
          ent_nxt    = '0;
          top_nxt    = first_top;
          halved_nxt = 1'b0;
          sw_nxt     = WW'(1);
          tw_nxt     = WW'(hccm_pkg::NSYM);
          state_nxt  = ST_RD;
        end
      end
      ST_HASH: begin
        h_nxt = h_mul;
        k_nxt = k_r + OW'(1);
        if (k_r == ord_r - OW'(1)) begin
          if (IS_POW2) begin
            ent_nxt   = h_mul[ENT_W-1:0];
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        quo_nxt   = 32'(quo_prod >> RECIP_SHIFT);
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        ent_nxt   = rem_full[ENT_W-1:0];
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (upd_r && !halved_r && int'(tot_rdata) > hccm_pkg::HALVE_LIMIT) begin
          hs_nxt    = '0;
          acc_nxt   = '0;
          state_nxt = ST_HALVE;
        end else begin
          if (upd_r) begin
            cnt_we = 1'b1;
            tot_we = 1'b1;
          end else if (tot_rdata != '0) begin
            sw_nxt = sw_r + cnt_wt[WW-1:0];
            tw_nxt = tw_r + tot_wt[WW-1:0];
          end
          if (ord_r == top_r) begin
            state_nxt = ST_DONE;
          end else begin
            ord_nxt    = ord_r + OW'(1);
            halved_nxt = 1'b0;
            h_nxt      = hccm_pkg::FNV_OFFSET;
            k_nxt      = '0;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HALVE: begin
        cnt_raddr = {node, hs_r[7:0]};
        if (hs_r != 9'd0) begin
          cnt_we    = 1'b1;
          cnt_waddr = {node, hs_r[7:0] - 8'd1};
          cnt_wdata = half_cnt;
          acc_nxt   = acc_r + 20'(half_cnt);
        end
        hs_nxt = hs_r + 9'd1;
        if (hs_r[8]) begin
          tot_we     = 1'b1;
          tot_wdata  = acc_nxt[CW-1:0];
          halved_nxt = 1'b1;
          state_nxt  = ST_RD;
        end
      end
      ST_DONE: begin
        if (upd_r) begin
          for (int i = 0; i < ORDER_LIMIT - 1; i++) begin
            hist_nxt[i] = hist_r[i+1];
          end
          hist_nxt[ORDER_LIMIT-1] = sym_r;
          if (int'(len_r) < ORDER_LIMIT) begin
            len_nxt = len_r + OW'(1);
          end
          state_nxt = ST_IDLE;
        end else if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          osw_nxt   = sw_r;
          otw_nxt   = tw_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      order_cap_r <= hccm_pkg::CFG_W'(hccm_pkg::CFG_RESET);
      len_r       <= '0;
      ov_r        <= 1'b0;
      for (int i = 0; i < ORDER_LIMIT; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
      for (int i = 0; i < ORDER_LIMIT; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
      if (cfg_we) begin
        order_cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_r    <= upd_nxt;
    sym_r    <= sym_nxt;
    ord_r    <= ord_nxt;
    top_r    <= top_nxt;
    k_r      <= k_nxt;
    h_r      <= h_nxt;
    quo_r    <= quo_nxt;
    ent_r    <= ent_nxt;
    halved_r <= halved_nxt;
    hs_r     <= hs_nxt;
    acc_r    <= acc_nxt;
    sw_r     <= sw_nxt;
    tw_r     <= tw_nxt;
    osw_r    <= osw_nxt;
    otw_r    <= otw_nxt;
  end
endmodule
`default_nettype wire

>>> sv/hashed_context_count_model.sv
// top level of the hashed context count model
// in_chan carries requests (req_type, symbol) under valid/ready; a query
// returns one transaction on out_chan with symbol_weight and total_weight,
// an update returns nothing. cfg_we/cfg_wdata set the highest order; the user must
// write them only while idle, the block does not enforce it. requests pass a two
// entry queue to a sequencer that handles them in turn. per request: an intake step
// pops the queue; order 0 reads and evaluates its table entry; each order o above
// it hashes its o latest symbols (one fnv multiply each), adds a multiply and a
// subtract step for the remainder when TABLE_ENTRIES is not a power of two, then
// reads and evaluates its entry; a closing step ends it. an update at a node whose
// total passes 4000 first halves that node's counts in a sweep through the count
// memory port. after reset a clearing pass writes zero to every count entry, one
// per cycle; in_chan.ready stays low meanwhile. the order register resets to 4,
// history empty. a stalled result is held in the output register; the queue keeps
// taking requests until full, and a further query waits for the register to free.
`default_nettype none
module hashed_context_count_model #(
  parameter int ORDER_LIMIT   = hccm_pkg::ORDER_LIMIT,
  parameter int TABLE_ENTRIES = hccm_pkg::TABLE_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hccm_in_if.sink                         in_chan,
  hccm_out_if.source                      out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [hccm_pkg::CFG_W-1:0] cfg_wdata
);
  logic            item_valid;
  logic            item_pop;
  logic            clearing;
  hccm_pkg::item_t item;

  hccm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .clearing(clearing),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  hccm_back #(.ORDER_LIMIT(ORDER_LIMIT), .TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .clearing(clearing), .out_chan(out_chan)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> clearing)
    else $error("clearing pass not started after reset");

  a_no_intake_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_chan.ready)
    else $error("request taken during clearing pass");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid && !clearing)
    else $error("queue popped while empty");
endmodule
`default_nettype wire

>>> test/tb.sv
// testbench for hashed_context_count_model: directed table, then random phases against a predictor
`default_nettype none
module tb;
  import hccm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = (ORDER_LIMIT + 1) * TABLE_ENTRIES;
  localparam int IDLE_LIMIT = 1000000;
  localparam int SETTLE = 4000;

  typedef struct {
    logic       is_update;
    logic [7:0] symbol;
    bit         fixed;
    int         sw;
    int         tw;
  } row_t;

  typedef struct {
    logic [WEIGHT_W-1:0] sw;
    logic [WEIGHT_W-1:0] tw;
  } weights_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  hccm_in_if in_c();
  hccm_out_if out_c();

  hashed_context_count_model dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_c), .out_chan(out_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [CNT_W-1:0] sym_counts[NODES*NSYM];
  logic [CNT_W-1:0] node_totals[NODES];
  logic [7:0] history[ORDER_LIMIT];
  int hist_count;
  int top_order;

  weights_t weight_q[$];
  int fails, n_sent, n_queries, n_checked, idle_cycles, burst_left, hold_len;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int node_of(int o);
    logic [31:0] h;
    h = FNV_OFFSET;
    if (o == 0) return 0;
    for (int i = ORDER_LIMIT - o; i < ORDER_LIMIT; i++) begin
      h = (h ^ {24'd0, history[i]}) * FNV_PRIME;
    end
    return o * TABLE_ENTRIES + int'(h % TABLE_ENTRIES);
  endfunction

  function automatic weights_t blend_weights(logic [7:0] s);
    weights_t r;
    logic [31:0] sw, tw;
    int n;
    sw = 1;
    tw = NSYM;
    for (int o = 0; o <= top_order && o <= hist_count; o++) begin
      n = node_of(o);
      if (node_totals[n] != 0) begin
        sw += 32'(sym_counts[n*NSYM + s]) << (2*o);
        tw += 32'(node_totals[n]) << (2*o);
      end
    end
    r.sw = sw[WEIGHT_W-1:0];
    r.tw = tw[WEIGHT_W-1:0];
    return r;
  endfunction

  function automatic void learn_symbol(logic [7:0] s);
    int n;
    logic [31:0] t;
    for (int o = 0; o <= top_order && o <= hist_count; o++) begin
      n = node_of(o);
      if (node_totals[n] > HALVE_LIMIT) begin
        t = 0;
        for (int k = 0; k < NSYM; k++) begin
          sym_counts[n*NSYM + k] = sym_counts[n*NSYM + k] >> 1;
          t += sym_counts[n*NSYM + k];
        end
        node_totals[n] = t[CNT_W-1:0];
      end
      sym_counts[n*NSYM + s] = sym_counts[n*NSYM + s] + 1'b1;
      node_totals[n] = node_totals[n] + 1'b1;
    end
    for (int i = 0; i < ORDER_LIMIT - 1; i++) history[i] = history[i+1];
    history[ORDER_LIMIT-1] = s;
    if (hist_count < ORDER_LIMIT) hist_count++;
  endfunction

  task automatic send_request(logic upd, logic [7:0] s, bit fixed, int sw, int tw);
    weights_t w;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_c.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_c.valid <= 1'b1;
    in_c.req_type <= upd;
    in_c.symbol <= s;
    if (upd == REQ_UPDATE) begin
      learn_symbol(s);
    end else begin
      if (fixed) begin
        w.sw = sw[WEIGHT_W-1:0];
        w.tw = tw[WEIGHT_W-1:0];
      end else begin
        w = blend_weights(s);
      end
      weight_q.push_back(w);
      n_queries++;
    end
    @(posedge clk);
    while (!in_c.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_c.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (weight_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_order(int v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    top_order = (v > ORDER_LIMIT) ? ORDER_LIMIT : v;
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_phase(int count, int upd_pct);
    logic upd;
    for (int i = 0; i < count; i++) begin
      upd = ($urandom_range(0, 99) < upd_pct) ? REQ_UPDATE : REQ_QUERY;
      send_request(upd, pick_symbol(), 1'b0, 0, 0);
    end
  endtask

  // receiver: stall pattern, long hold-off on request, result check
  initial begin
    int mode_cnt, mode;
    weights_t w;
    mode_cnt = 0;
    mode = 0;
    out_c.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_c.valid && out_c.ready) begin
        if (weight_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fails++;
        end else begin
          w = weight_q.pop_front();
          n_checked++;
          if (out_c.symbol_weight !== w.sw) begin
            $error("symbol_weight expected %0d actual %0d", w.sw, out_c.symbol_weight);
            fails++;
          end
          if (out_c.total_weight !== w.tw) begin
            $error("total_weight expected %0d actual %0d", w.tw, out_c.total_weight);
            fails++;
          end
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        out_c.ready <= 1'b0;
      end else begin
        if (mode_cnt == 0) begin
          mode = $urandom_range(0, 3);
          mode_cnt = $urandom_range(16, 96);
        end
        mode_cnt--;
        case (mode)
          0: out_c.ready <= 1'b1;
          1: out_c.ready <= 1'($urandom_range(0, 1));
          2: out_c.ready <= ($urandom_range(0, 3) == 0);
          default: out_c.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** hashed_context_count_model: FAILED **");
        $finish;
      end
    end
  end

  row_t dir_rows[21] = '{
    '{REQ_QUERY,  8'h00, 1'b1, 1, 256},
    '{REQ_QUERY,  8'hFF, 1'b1, 1, 256},
    '{REQ_UPDATE, 8'h00, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h00, 1'b1, 2, 257},
    '{REQ_QUERY,  8'hFF, 1'b1, 1, 257},
    '{REQ_UPDATE, 8'hFF, 1'b0, 0, 0},
    '{REQ_QUERY,  8'hFF, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'hA5, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'h5A, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h5A, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'h00, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'hFF, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'hA5, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h5A, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'h5A, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h00, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'h00, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'hFF, 1'b0, 0, 0},
    '{REQ_UPDATE, 8'hA5, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h5A, 1'b0, 0, 0},
    '{REQ_QUERY,  8'h01, 1'b0, 0, 0}
  };

  initial begin
    fails = 0; n_sent = 0; n_queries = 0; n_checked = 0; burst_left = 0; hold_len = 0;
    for (int i = 0; i < NODES*NSYM; i++) sym_counts[i] = '0;
    for (int i = 0; i < NODES; i++) node_totals[i] = '0;
    for (int i = 0; i < ORDER_LIMIT; i++) history[i] = '0;
    hist_count = 0;
    top_order = CFG_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_c.valid = 1'b0;
    in_c.req_type = REQ_QUERY;
    in_c.symbol = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].is_update, dir_rows[i].symbol, dir_rows[i].fixed,
                   dir_rows[i].sw, dir_rows[i].tw);
    drain();

    set_order(4);
    hold_len = 500;
    random_phase(200, 60);
    drain();
    set_order(0);
    random_phase(120, 50);
    drain();
    set_order(7);
    random_phase(150, 55);
    drain();
    set_order(2);
    random_phase(120, 50);
    drain();
    set_order(1);
    random_phase(100, 50);
    drain();
    set_order(3);
    random_phase(120, 60);
    drain();
    set_order(4);
    random_phase(100, 50);
    drain();

    $display("%0d requests sent, %0d query results checked over order limits 0 to 7",
             n_sent, n_checked);
    if (fails == 0) begin
      $display("** hashed_context_count_model: PASSED **");
    end else begin
      $display("** hashed_context_count_model: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
sv/hccm_pkg.sv
sv/hccm_if.sv
sv/hccm_ram.sv
sv/hccm_front.sv
sv/hccm_back.sv
sv/hashed_context_count_model.sv
test/tb.sv
